/* rtl/rcma_pkg.sv */
// Package for the RC mode activation block: sizes, register indexes,
// state and struct types, and the AND/OR fold function.
// No dependencies.
package rcma_pkg;

    localparam int NUM_CONDITIONS = 32;
    localparam int NUM_MODES      = 64;

    localparam int CIDX_W     = (NUM_CONDITIONS > 1) ? $clog2(NUM_CONDITIONS) : 1;
    localparam int MODE_W     = $clog2(NUM_MODES);
    localparam int IN_W       = 56;   // input tdata width, whole bytes
    localparam int OUT_W      = 64;   // result tdata width
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_STICKY_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICKY_EN = 1'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    // input tdata layout, msb first
    typedef struct packed {
        logic        boot_delay_elapsed;
        logic [31:0] range_active_bits;
        logic        cond_nonempty;
        logic [7:0]  cond_link_mode;
        logic        cond_logic_and;
        logic [7:0]  cond_mode_id;
        logic [4:0]  cond_index;
    } in_item_t;

    typedef struct packed {
        logic       nonempty;
        logic [7:0] link_mode;
        logic       logic_and;
        logic [7:0] mode_id;
    } cond_entry_t;

    typedef struct packed {
        logic              load;
        logic              step1;
        logic              step2;
        logic              commit;
        logic              emit;
        logic [CIDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    // returns {and_bit, new_bit}
    function automatic logic [1:0] fold_bits(input logic logic_and, input logic active,
                                             input logic and_b, input logic new_b);
        logic [1:0] r;
        r = {and_b, new_b};
        if (and_b || !new_b) begin
            if (!logic_and) begin
                if (active) begin
                    r = 2'b01;
                end
            end else begin
                r[1] = 1'b1;
                if (!active) begin
                    r[0] = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

/* rtl/rcma_ctrl.sv */
// Controller FSM for the RC mode activation block: accepts items and
// sequences the two table passes. Depends on rcma_pkg.
module rcma_ctrl import rcma_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [CIDX_W-1:0] idx_reg, idx_next;
    logic              last;

    assign last = (idx_reg == CIDX_W'(NUM_CONDITIONS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_tvalid) begin
                    state_next = (s_tuser == OP_EVAL) ? ST_PASS1 : ST_EMIT;
                end
            end
            ST_PASS1: begin
                idx_next = last ? '0 : idx_reg + 1'b1;
                if (last) begin
                    state_next = ST_PASS2;
                end
            end
            ST_PASS2: begin
                idx_next = last ? '0 : idx_reg + 1'b1;
                if (last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.idx  = idx_reg;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_PASS1:  cmd.step1  = 1'b1;
            ST_PASS2:  cmd.step2  = 1'b1;
            ST_COMMIT: cmd.commit = 1'b1;
            ST_EMIT:   cmd.emit   = !status.out_busy;
            default: begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/rcma_datapath.sv */
// Datapath for the RC mode activation block: condition table, AND/NEW
// masks, sticky state, config registers and result register. Depends on rcma_pkg.
module rcma_datapath import rcma_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_W-1:0]      m_tdata
);

    in_item_t item;
    assign item = in_item_t'(s_tdata);

    cond_entry_t                table_reg [NUM_CONDITIONS];
    logic [NUM_CONDITIONS-1:0]  range_reg;
    logic                       boot_reg;
    logic [NUM_MODES-1:0]       and_reg, and_next;
    logic [NUM_MODES-1:0]       new_reg, new_next;
    logic [NUM_MODES-1:0]       active_reg;
    logic [NUM_MODES-1:0]       sted_reg, sted_next;
    logic [5:0]                 sticky_id_reg;
    logic                       sticky_en_reg;
    logic                       m_tvalid_reg;
    logic [OUT_W-1:0]           m_tdata_reg;

    cond_entry_t       entry;
    logic [MODE_W-1:0] mb, lb;
    logic              m_ok, l_ok, act, skip1, is_sticky;
    logic [1:0]        folded;

    always_comb begin
        entry     = table_reg[cmd.idx];
        mb        = entry.mode_id[MODE_W-1:0];
        lb        = entry.link_mode[MODE_W-1:0];
        m_ok      = (entry.mode_id < 8'(NUM_MODES));
        l_ok      = (entry.link_mode < 8'(NUM_MODES));
        skip1     = (entry.link_mode != 8'd0) || !entry.nonempty || !m_ok;
        is_sticky = sticky_en_reg && (entry.mode_id == {2'b00, sticky_id_reg});
        act       = 1'b0;
        and_next  = and_reg;
        new_next  = new_reg;
        sted_next = sted_reg;
        folded    = 2'b00;
        if (cmd.load) begin
            and_next = '0;
            new_next = '0;
        end else if (cmd.step1 && !skip1) begin
            act    = range_reg[cmd.idx];
            folded = fold_bits(entry.logic_and, act, and_reg[mb], new_reg[mb]);
            if (is_sticky) begin
                if (active_reg[mb]) begin
                    and_next[mb] = 1'b0;
                    new_next[mb] = 1'b1;
                end else if (sted_reg[mb]) begin
                    and_next[mb] = folded[1];
                    new_next[mb] = folded[0];
                end else if (boot_reg && !act) begin
                    sted_next[mb] = 1'b1;
                end
            end else begin
                and_next[mb] = folded[1];
                new_next[mb] = folded[0];
            end
        end else if (cmd.step2 && (entry.link_mode != 8'd0) && m_ok) begin
            // linked condition follows the linked mode's current state
            act          = l_ok && (and_reg[lb] != new_reg[lb]);
            folded       = fold_bits(entry.logic_and, act, and_reg[mb], new_reg[mb]);
            and_next[mb] = folded[1];
            new_next[mb] = folded[0];
        end
    end

    always_ff @(posedge aclk) begin
        and_reg <= and_next;
        new_reg <= new_next;
        if (cmd.load) begin
            range_reg <= item.range_active_bits[NUM_CONDITIONS-1:0];
            boot_reg  <= item.boot_delay_elapsed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CONDITIONS; i++) begin
                table_reg[i] <= '0;
            end
            active_reg    <= '0;
            sted_reg      <= '0;
            sticky_id_reg <= '0;
            sticky_en_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            sted_reg <= sted_next;
            if (cmd.load && (s_tuser == OP_WRITE) &&
                ({1'b0, item.cond_index} < 6'(NUM_CONDITIONS))) begin
                table_reg[item.cond_index[CIDX_W-1:0]] <= '{
                    nonempty:  item.cond_nonempty,
                    link_mode: item.cond_link_mode,
                    logic_and: item.cond_logic_and,
                    mode_id:   item.cond_mode_id
                };
            end
            if (cmd.commit) begin
                active_reg <= and_reg ^ new_reg;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_STICKY_ID: sticky_id_reg <= cfg_data[5:0];
                    CFG_STICKY_EN: sticky_en_reg <= cfg_data[0];
                    default: begin
                        sticky_en_reg <= sticky_en_reg;
                    end
                endcase
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= OUT_W'(active_reg);
        end
    end

    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

/* rtl/rc_mode_activation_logic.sv */
// RC mode activation block, top level: controller plus datapath.
// Depends on rcma_pkg, rcma_ctrl and rcma_datapath.
//
// Input stream (s_*): s_tuser selects the item kind, write (0) or evaluate (1).
// A write stores one condition in the 32-entry table; an evaluate takes one
// range-active bit per condition and recomputes the 64-bit mode set.
// Every item yields exactly one transfer on the result stream (m_*): the
// mode set after that item.
// Config channel (cfg_*): always ready; index 0 is the sticky mode id,
// index 1 the sticky enable. Write it only while the block is idle.
// An evaluate runs two passes that walk the table one entry per cycle, then
// a commit and an emit; a write goes straight to the emit. One item is in
// work at a time; s_tready returns as the result is loaded into the output
// register, together with m_tvalid.
// A result waiting on m_tready does not block the next accept; a second
// result waits in the controller until the output register drains.
// Reset (aresetn low, synchronous) clears the table, mode set, sticky
// history, config registers and the output valid.
module rc_mode_activation_logic import rcma_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [4:0] cond_index, [12:5] cond_mode_id, [13] cond_logic_and,
    // [21:14] cond_link_mode, [22] cond_nonempty, [54:23] range_active_bits,
    // [55] boot_delay_elapsed
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  s_tuser,   // [0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [63:0] mode_bits
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rcma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rcma_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/rcma_checker.sv */
// Port-level checker for rc_mode_activation_logic, bound to the top level.
// Depends on rcma_pkg.
module rcma_checker import rcma_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_W-1:0]      m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // an evaluation walks the table, so it is still busy well after the accept
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_EVAL) |=> ##1 !s_tready)
        else $error("evaluation finished too early");

    // modes beyond the mode count never show up
    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >> NUM_MODES) == '0))
        else $error("mode bit beyond mode count set");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind rc_mode_activation_logic rcma_checker u_rcma_checker (.*);

/* verif/tb_rc_mode_activation_logic.sv */
// Testbench for rc_mode_activation_logic: drives condition writes and evaluations,
// predicts the mode set in a scoreboard class and compares every result transfer.
// Depends on rcma_pkg and the RTL of the block only.
import rcma_pkg::*;

class mode_scoreboard;
    typedef struct packed {
        logic [7:0] mode;
        logic       and_logic;
        logic [7:0] link;
        logic       used;
    } slot_t;

    slot_t       slots [NUM_CONDITIONS];
    logic [63:0] modes_now;
    logic [63:0] sticky_off_seen;
    logic [63:0] acc_and;
    logic [63:0] acc_new;
    logic [5:0]  sticky_id;
    logic        sticky_on;
    logic [63:0] expected_modes [$];
    int          failures;
    int          n_checked;

    function new();
        foreach (slots[i]) slots[i] = '0;
        modes_now       = '0;
        sticky_off_seen = '0;
        sticky_id       = '0;
        sticky_on       = 1'b0;
        failures        = 0;
        n_checked       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        if (idx == CFG_STICKY_ID) begin
            sticky_id = d[5:0];
        end else if (idx == CFG_STICKY_EN) begin
            sticky_on = d[0];
        end
    endfunction

    // a mode already forced on by OR (and=0, new=1) is left alone
    function void fold(int m, logic and_logic, logic act);
        if (!acc_and[m] && acc_new[m]) return;
        if (and_logic) begin
            acc_and[m] = 1'b1;
            if (!act) acc_new[m] = 1'b1;
        end else if (act) begin
            acc_and[m] = 1'b0;
            acc_new[m] = 1'b1;
        end
    endfunction

    function void evaluate(logic [31:0] ranges, logic boot);
        int   m;
        int   l;
        logic act;
        acc_and = '0;
        acc_new = '0;
        for (int i = 0; i < NUM_CONDITIONS; i++) begin
            m = slots[i].mode;
            if (slots[i].link == 0 && slots[i].used && m < NUM_MODES) begin
                if (sticky_on && m == sticky_id) begin
                    if (modes_now[m]) begin
                        acc_and[m] = 1'b0;
                        acc_new[m] = 1'b1;
                    end else if (sticky_off_seen[m]) begin
                        fold(m, slots[i].and_logic, ranges[i]);
                    end else if (boot && !ranges[i]) begin
                        sticky_off_seen[m] = 1'b1;
                    end
                end else begin
                    fold(m, slots[i].and_logic, ranges[i]);
                end
            end
        end
        // linked conditions follow the partial result of the first pass
        for (int i = 0; i < NUM_CONDITIONS; i++) begin
            m = slots[i].mode;
            l = slots[i].link;
            if (l != 0 && m < NUM_MODES) begin
                act = (l < NUM_MODES) ? (acc_and[l] ^ acc_new[l]) : 1'b0;
                fold(m, slots[i].and_logic, act);
            end
        end
        modes_now = acc_and ^ acc_new;
    endfunction

    function void note_item(logic op, in_item_t it);
        if (op == OP_WRITE) begin
            if (int'(it.cond_index) < NUM_CONDITIONS) begin
                slots[it.cond_index] = '{mode: it.cond_mode_id, and_logic: it.cond_logic_and,
                                         link: it.cond_link_mode, used: it.cond_nonempty};
            end
        end else begin
            evaluate(it.range_active_bits, it.boot_delay_elapsed);
        end
        expected_modes.push_back(modes_now);
    endfunction

    function void check_modes(logic [63:0] got);
        logic [63:0] want;
        n_checked++;
        if (expected_modes.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result transfer: mode_bits=%h", got);
        end else begin
            want = expected_modes.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("mode_bits mismatch at result %0d: expected %h, got %h",
                             n_checked, want, got);
                end
            end
        end
    endfunction

    function void close_out();
        if (expected_modes.size() != 0) begin
            if (failures < 10) begin
                $display("%0d expected results never arrived", expected_modes.size());
            end
            failures += expected_modes.size();
        end
    endfunction
endclass

module tb_rc_mode_activation_logic;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 1000000;
    localparam int SETTLE      = 80;
    localparam int PHASE_ITEMS = 246;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LO    = 500;
    localparam int QUIET_HI    = 700;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mode_scoreboard sb;
    int             n_sent;
    int             cycles;
    bit             held;

    rc_mode_activation_logic i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[rc_mode_activation_logic] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_modes(m_tdata);
        end
    end

    // result side: random backpressure, one long hold-off, and a quiet stretch
    initial begin
        m_tready = 1'b0;
        held     = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && sb != null && sb.n_checked >= HOLD_AT) begin
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
                held = 1'b1;
            end
            if (sb != null && sb.n_checked >= QUIET_LO && sb.n_checked < QUIET_HI) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    function automatic in_item_t filler();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return in_item_t'(r[55:0]);
    endfunction

    // entered and left at a falling edge
    task automatic send_item(logic op, in_item_t it);
        while (!(n_sent >= QUIET_LO && n_sent < QUIET_HI) && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(op, it);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic send_write(int idx, int mode, bit land, int link, bit used);
        in_item_t it;
        it                = filler();
        it.cond_index     = idx[4:0];
        it.cond_mode_id   = mode[7:0];
        it.cond_logic_and = land;
        it.cond_link_mode = link[7:0];
        it.cond_nonempty  = used;
        send_item(OP_WRITE, it);
    endtask

    task automatic send_eval(logic [31:0] ranges, bit boot);
        in_item_t it;
        it                    = filler();
        it.range_active_bits  = ranges;
        it.boot_delay_elapsed = boot;
        send_item(OP_EVAL, it);
    endtask

    task automatic set_sticky(int id, bit en);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_STICKY_ID;
        cfg_data  <= id[5:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(CFG_STICKY_ID, id[5:0]);
        @(negedge aclk);
        cfg_index <= CFG_STICKY_EN;
        cfg_data  <= {5'd0, en};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(CFG_STICKY_EN, {5'd0, en});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait out all results plus the block's latency; leaves at a falling edge
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_modes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    // small mode set so conditions collide, with the top mode and junk ids mixed in
    function automatic int pick_mode();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) return $urandom_range(0, 7);
        if (p < 88) return 63;
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_link();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 93) return $urandom_range(1, 7);
        return $urandom_range(0, 255);
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            send_item(1'($urandom_range(0, 1)), filler());
        end else if (r < 66) begin
            send_write($urandom_range(0, NUM_CONDITIONS - 1), pick_mode(),
                       1'($urandom_range(0, 1)), pick_link(), $urandom_range(0, 99) < 85);
        end else begin
            send_eval($urandom, $urandom_range(0, 99) < 80);
        end
    endtask

    initial begin
        int sticky_ids [5] = '{63, 3, 2, 5, 63};
        bit sticky_ens [5] = '{1, 1, 0, 1, 0};
        sb        = new();
        n_sent    = 0;
        cycles    = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_WRITE;
        cfg_valid = 1'b0;
        cfg_index = CFG_STICKY_ID;
        cfg_data  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: sticky mode 0 armed
        set_sticky(0, 1'b1);
        send_eval(32'h0, 1'b0);
        send_write(0, 0, 1'b0, 0, 1'b1);
        send_eval(32'h1, 1'b0);                 // before boot delay: sticky not armed
        send_eval(32'h0, 1'b1);                 // seen off after boot
        send_eval(32'h1, 1'b1);                 // turns on
        send_eval(32'h0, 1'b0);                 // stays latched
        send_write(31, 63, 1'b1, 0, 1'b1);
        send_eval(32'hFFFF_FFFF, 1'b1);
        send_eval(32'h0, 1'b1);
        send_write(2, 64, 1'b0, 0, 1'b1);       // mode id out of range, low bits alias sticky
        send_write(3, 5, 1'b0, 0, 1'b0);        // empty entry
        send_write(4, 6, 1'b0, 63, 1'b0);       // linked, empty flag ignored
        send_write(5, 7, 1'b1, 200, 1'b1);      // linked mode out of range
        send_write(6, 255, 1'b1, 255, 1'b1);    // linked with mode out of range
        send_eval(32'hFFFF_FFFF, 1'b1);
        send_eval(32'h8000_0000, 1'b1);
        send_write(1, 63, 1'b0, 0, 1'b1);       // OR and AND on one mode
        send_eval(32'h0000_0002, 1'b1);
        send_eval(32'h8000_0000, 1'b0);
        send_write(31, 255, 1'b1, 255, 1'b1);
        send_write(0, 0, 1'b0, 0, 1'b0);
        send_eval(32'h0, 1'b0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            set_sticky(sticky_ids[ph], sticky_ens[ph]);
            repeat (PHASE_ITEMS) random_item();
            drain();
        end

        sb.close_out();
        if (sb.failures == 0) begin
            $display("[rc_mode_activation_logic] OK");
        end else begin
            $display("[rc_mode_activation_logic] ERROR");
        end
        $finish;
    end
endmodule
